@@ hdl/msct_pkg.sv @@
// ---------------------------------------------------------------------------
// Map/screen coordinate transform package
// Shared widths, pipeline depths and register indexes of the transform core.
// ---------------------------------------------------------------------------
package msct_pkg;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int SPAN_W  = 31;
   localparam int TRIG_W  = 22;
   localparam int PIXEL_W = 16;

   // Both scale constants are 1024, so their divisions become shifts.
   localparam int SCALE_SHIFT = 10;
   localparam int ROT_SHIFT   = 10;

   // Scaled map offset: 33-bit difference shifted by the screen scale.
   localparam int NUM_W  = COORD_W + 1 + SCALE_SHIFT;
   localparam int QUOT_W = NUM_W + 1;

   // One quotient bit per divider stage.
   localparam int DIV_STAGES = NUM_W;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_MAP_CENTER_X   = 3'd0,
      CSR_MAP_CENTER_Y   = 3'd1,
      CSR_MAP_SPAN_X     = 3'd2,
      CSR_MAP_SPAN_Y     = 3'd3,
      CSR_COS_FACTOR     = 3'd4,
      CSR_SIN_FACTOR     = 3'd5,
      CSR_PIXEL_CENTER_X = 3'd6,
      CSR_PIXEL_CENTER_Y = 3'd7
   } csr_index_type;

   // Request kinds.
   localparam logic OP_MAP_TO_BITMAP = 1'b0;
   localparam logic OP_BITMAP_TO_MAP = 1'b1;

endpackage

@@ hdl/msct_div.sv @@
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a magnitude by an unsigned span, one quotient bit per stage, and
// applies the sign at the end so the quotient truncates toward zero.
// ---------------------------------------------------------------------------
module msct_div (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [msct_pkg::NUM_W-1:0]           num_mag,
   input  logic                                 num_neg,
   input  logic [msct_pkg::SPAN_W-1:0]          divisor,
   output logic signed [msct_pkg::QUOT_W-1:0]   quotient
);

   localparam int N = msct_pkg::DIV_STAGES;

   logic [msct_pkg::SPAN_W-1:0] rem_ff  [N];
   logic [msct_pkg::SPAN_W-1:0] rem_in  [N];
   logic [msct_pkg::NUM_W-1:0]  work_ff [N];
   logic [msct_pkg::NUM_W-1:0]  work_in [N];
   logic                        neg_ff  [N];
   logic                        neg_in  [N];
   logic [msct_pkg::SPAN_W:0]   trial   [N];
   logic                        fits    [N];

   // Each stage brings down one numerator bit and tries a subtraction.
   always_comb begin
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            trial[s]  = {{msct_pkg::SPAN_W{1'b0}}, num_mag[msct_pkg::NUM_W-1]};
            neg_in[s] = num_neg;
            work_in[s] = {num_mag[msct_pkg::NUM_W-2:0], 1'b0};
         end else begin
            trial[s]  = {rem_ff[s-1], work_ff[s-1][msct_pkg::NUM_W-1]};
            neg_in[s] = neg_ff[s-1];
            work_in[s] = {work_ff[s-1][msct_pkg::NUM_W-2:0], 1'b0};
         end
         fits[s] = trial[s] >= {1'b0, divisor};
         if (fits[s]) begin
            rem_in[s] = msct_pkg::SPAN_W'(trial[s] - {1'b0, divisor});
         end else begin
            rem_in[s] = trial[s][msct_pkg::SPAN_W-1:0];
         end
         work_in[s][0] = fits[s];
      end
   end

   // Stage registers advance together with the rest of the pipeline.
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < N; s++) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            neg_ff[s]  <= neg_in[s];
         end
      end
   end

   // Apply the numerator's sign to the quotient.
   always_comb begin
      if (neg_ff[N-1]) begin
         quotient = -$signed({1'b0, work_ff[N-1]});
      end else begin
         quotient = $signed({1'b0, work_ff[N-1]});
      end
   end

endmodule

@@ hdl/map_screen_coordinate_transform_core.sv @@
// ---------------------------------------------------------------------------
// Map/screen coordinate transform core
// Scales, rotates and translates one point per request, map to bitmap or
// bitmap to map, in a single deep pipeline.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Contents
// req_      in         tdata: point_x, point_y; tuser: opcode
// rsp_      out        tdata: result_x, result_y; tuser: ok
// csr_      in         write enable, register index, write data
//
// A request is accepted every cycle in which the pipeline advances; the depth is
// set by the 43 stages of the restoring divider for the map span.
// All stages advance together whenever the response register is empty or
// being taken, so a stall holds every stage in place.
// Reset is synchronous and clears the valid bits and configuration registers, but sets the cosine factor to 1024.
// ---------------------------------------------------------------------------
module map_screen_coordinate_transform_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x [31:0], point_y [63:32]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_x [31:0], result_y [63:32]
   output logic        rsp_tuser,   // ok
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int N      = msct_pkg::DIV_STAGES;
   localparam int QW     = msct_pkg::QUOT_W;
   localparam int RW     = 64 - msct_pkg::ROT_SHIFT;
   localparam int ROUNDR = (1 << msct_pkg::ROT_SHIFT) - 1;
   localparam int ROUNDS = (1 << msct_pkg::SCALE_SHIFT) - 1;

   // Configuration registers.
   logic signed [31:0] map_center_x_ff, map_center_y_ff;
   logic [30:0]        map_span_x_ff, map_span_y_ff;
   logic signed [21:0] cos_factor_ff, sin_factor_ff;
   logic signed [15:0] pixel_center_x_ff, pixel_center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_center_x_ff   <= '0;
         map_center_y_ff   <= '0;
         map_span_x_ff     <= '0;
         map_span_y_ff     <= '0;
         cos_factor_ff     <= 22'sd1024;
         sin_factor_ff     <= '0;
         pixel_center_x_ff <= '0;
         pixel_center_y_ff <= '0;
      end else if (csr_we) begin
         unique case (msct_pkg::csr_index_type'(csr_index))
            msct_pkg::CSR_MAP_CENTER_X:   map_center_x_ff   <= csr_wdata;
            msct_pkg::CSR_MAP_CENTER_Y:   map_center_y_ff   <= csr_wdata;
            msct_pkg::CSR_MAP_SPAN_X:     map_span_x_ff     <= csr_wdata[30:0];
            msct_pkg::CSR_MAP_SPAN_Y:     map_span_y_ff     <= csr_wdata[30:0];
            msct_pkg::CSR_COS_FACTOR:     cos_factor_ff     <= csr_wdata[21:0];
            msct_pkg::CSR_SIN_FACTOR:     sin_factor_ff     <= csr_wdata[21:0];
            msct_pkg::CSR_PIXEL_CENTER_X: pixel_center_x_ff <= csr_wdata[15:0];
            msct_pkg::CSR_PIXEL_CENTER_Y: pixel_center_y_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Global advance: the whole pipeline moves when the output can take data.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 0: input register.
   logic               v0_ff, op0_ff;
   logic signed [31:0] px0_ff, py0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff <= req_tuser;
         px0_ff <= req_tdata[31:0];
         py0_ff <= req_tdata[63:32];
      end
   end

   // Stage 1: offsets, scaled numerators and their magnitudes.
   logic signed [32:0]                 dxo, dyo, ux_in, uy_in;
   logic signed [msct_pkg::NUM_W:0]    numx, numy;
   logic [msct_pkg::NUM_W-1:0]         magx_in, magy_in;
   logic                               ok_in;

   always_comb begin
      dxo   = 33'(px0_ff) - 33'(map_center_x_ff);
      dyo   = 33'(map_center_y_ff) - 33'(py0_ff);
      ux_in = 33'(px0_ff) - 33'(pixel_center_x_ff);
      uy_in = 33'(py0_ff) - 33'(pixel_center_y_ff);
      numx  = (msct_pkg::NUM_W + 1)'(dxo) <<< msct_pkg::SCALE_SHIFT;
      numy  = (msct_pkg::NUM_W + 1)'(dyo) <<< msct_pkg::SCALE_SHIFT;
      magx_in = numx[msct_pkg::NUM_W] ? msct_pkg::NUM_W'(-numx) : msct_pkg::NUM_W'(numx);
      magy_in = numy[msct_pkg::NUM_W] ? msct_pkg::NUM_W'(-numy) : msct_pkg::NUM_W'(numy);
      ok_in   = (op0_ff == msct_pkg::OP_BITMAP_TO_MAP) ||
                ((map_span_x_ff != '0) && (map_span_y_ff != '0));
   end

   logic                       v1_ff, op1_ff, ok1_ff, negx1_ff, negy1_ff;
   logic signed [32:0]         ux1_ff, uy1_ff;
   logic [msct_pkg::NUM_W-1:0] magx1_ff, magy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff   <= op0_ff;
         ok1_ff   <= ok_in;
         ux1_ff   <= ux_in;
         uy1_ff   <= uy_in;
         magx1_ff <= magx_in;
         magy1_ff <= magy_in;
         negx1_ff <= numx[msct_pkg::NUM_W];
         negy1_ff <= numy[msct_pkg::NUM_W];
      end
   end

   // Divider stages: two dividers plus side data moving alongside.
   logic signed [QW-1:0] qx, qy;

   msct_div u_div_x (
      .clock    (clock),
      .enable   (adv),
      .num_mag  (magx1_ff),
      .num_neg  (negx1_ff),
      .divisor  (map_span_x_ff),
      .quotient (qx)
   );

   msct_div u_div_y (
      .clock    (clock),
      .enable   (adv),
      .num_mag  (magy1_ff),
      .num_neg  (negy1_ff),
      .divisor  (map_span_y_ff),
      .quotient (qy)
   );

   logic               vd_ff  [N];
   logic               opd_ff [N];
   logic               okd_ff [N];
   logic signed [32:0] uxd_ff [N];
   logic signed [32:0] uyd_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < N; s++) begin
            vd_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vd_ff[0] <= v1_ff;
         for (int s = 1; s < N; s++) begin
            vd_ff[s] <= vd_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opd_ff[0] <= op1_ff;
         okd_ff[0] <= ok1_ff;
         uxd_ff[0] <= ux1_ff;
         uyd_ff[0] <= uy1_ff;
         for (int s = 1; s < N; s++) begin
            opd_ff[s] <= opd_ff[s-1];
            okd_ff[s] <= okd_ff[s-1];
            uxd_ff[s] <= uxd_ff[s-1];
            uyd_ff[s] <= uyd_ff[s-1];
         end
      end
   end

   // Rotation operand select; bitmap to map uses the negated sine.
   logic               vr_ff, opr_ff, okr_ff;
   logic signed [QW-1:0] ar_ff, br_ff;
   logic signed [22:0]   sr_ff;
   logic signed [QW-1:0] ar_in, br_in;
   logic signed [22:0]   sr_in;

   always_comb begin
      if (opd_ff[N-1] == msct_pkg::OP_BITMAP_TO_MAP) begin
         ar_in = QW'(uxd_ff[N-1]);
         br_in = QW'(uyd_ff[N-1]);
         sr_in = -23'(sin_factor_ff);
      end else begin
         ar_in = qx;
         br_in = qy;
         sr_in = 23'(sin_factor_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= vd_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opr_ff <= opd_ff[N-1];
         okr_ff <= okd_ff[N-1];
         ar_ff  <= ar_in;
         br_ff  <= br_in;
         sr_ff  <= sr_in;
      end
   end

   // Rotation products.
   logic               vm_ff, opm_ff, okm_ff;
   logic signed [66:0] ac_ff, bs_ff, bc_ff, as_ff;
   logic signed [66:0] ac_in, bs_in, bc_in, as_in;

   always_comb begin
      ac_in = ar_ff * cos_factor_ff;
      bs_in = br_ff * sr_ff;
      bc_in = br_ff * cos_factor_ff;
      as_in = ar_ff * sr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opm_ff <= opr_ff;
         okm_ff <= okr_ff;
         ac_ff  <= ac_in;
         bs_ff  <= bs_in;
         bc_ff  <= bc_in;
         as_ff  <= as_in;
      end
   end

   // Rotation sums, wrapped to 64 bits.
   logic               vs_ff, ops_ff, oks_ff;
   logic signed [63:0] xs_ff, ys_ff;
   logic [66:0]        xsum, ysum;

   assign xsum = ac_ff + bs_ff;
   assign ysum = bc_ff - as_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (adv) begin
         vs_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ops_ff <= opm_ff;
         oks_ff <= okm_ff;
         xs_ff  <= xsum[63:0];
         ys_ff  <= ysum[63:0];
      end
   end

   // Truncating divide by the rotation unit.
   logic               vq_ff, opq_ff, okq_ff;
   logic signed [RW-1:0] rx_ff, ry_ff;
   logic signed [63:0]   xb, yb;

   always_comb begin
      xb = xs_ff + (xs_ff[63] ? 64'(ROUNDR) : 64'd0);
      yb = ys_ff + (ys_ff[63] ? 64'(ROUNDR) : 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else if (adv) begin
         vq_ff <= vs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opq_ff <= ops_ff;
         okq_ff <= oks_ff;
         rx_ff  <= xb[63:msct_pkg::ROT_SHIFT];
         ry_ff  <= yb[63:msct_pkg::ROT_SHIFT];
      end
   end

   // Bitmap results, and the split span products for the inverse.
   logic               vp_ff, opp_ff, okp_ff;
   logic [31:0]        bmx_ff, bmy_ff;
   logic [63:0]        plx_ff, phx_ff, ply_ff, phy_ff;
   logic signed [RW:0] nsy;
   logic signed [70:0] plx_in, ply_in;
   logic signed [69:0] phx_in, phy_in;

   always_comb begin
      nsy    = -(RW + 1)'(ry_ff);
      plx_in = rx_ff * $signed({1'b0, map_span_x_ff[15:0]});
      phx_in = rx_ff * $signed({1'b0, map_span_x_ff[30:16]});
      ply_in = nsy * $signed({1'b0, map_span_y_ff[15:0]});
      phy_in = nsy * $signed({1'b0, map_span_y_ff[30:16]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= vq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opp_ff <= opq_ff;
         okp_ff <= okq_ff;
         bmx_ff <= rx_ff[31:0] + 32'(pixel_center_x_ff);
         bmy_ff <= ry_ff[31:0] + 32'(pixel_center_y_ff);
         plx_ff <= plx_in[63:0];
         phx_ff <= phx_in[63:0];
         ply_ff <= ply_in[63:0];
         phy_ff <= phy_in[63:0];
      end
   end

   // Combine the span partial products.
   logic        vc_ff, opc_ff, okc_ff;
   logic [31:0] bcx_ff, bcy_ff;
   logic [63:0] prx_ff, pry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opc_ff <= opp_ff;
         okc_ff <= okp_ff;
         bcx_ff <= bmx_ff;
         bcy_ff <= bmy_ff;
         prx_ff <= plx_ff + {phx_ff[47:0], 16'd0};
         pry_ff <= ply_ff + {phy_ff[47:0], 16'd0};
      end
   end

   // Scale divide, map centre and result selection into the output register.
   logic [63:0] pxb, pyb;
   logic [31:0] mapx, mapy, resx_in, resy_in;

   always_comb begin
      pxb  = prx_ff + (prx_ff[63] ? 64'(ROUNDS) : 64'd0);
      pyb  = pry_ff + (pry_ff[63] ? 64'(ROUNDS) : 64'd0);
      mapx = pxb[msct_pkg::SCALE_SHIFT +: 32] + map_center_x_ff;
      mapy = pyb[msct_pkg::SCALE_SHIFT +: 32] + map_center_y_ff;
      if (!okc_ff) begin
         resx_in = '0;
         resy_in = '0;
      end else if (opc_ff == msct_pkg::OP_BITMAP_TO_MAP) begin
         resx_in = mapx;
         resy_in = mapy;
      end else begin
         resx_in = bcx_ff;
         resy_in = bcy_ff;
      end
   end

   logic        out_v_ff, out_ok_ff;
   logic [63:0] out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {resy_in, resx_in};
         out_ok_ff   <= okc_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ok_ff;

   // A failed request always reports zero coordinates.
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 64'd0))
      else $error("failed request with nonzero coordinates");

   // The input side is ready exactly when the pipeline can advance.
   a_ready : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow the pipeline advance");

   // While the output stalls, the stage before the output register keeps its item.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(vc_ff) && $stable(prx_ff)))
      else $error("pipeline moved during a stall");

   // An accepted request shows up as a valid item in the first stage.
   a_enter : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v0_ff)
      else $error("accepted request lost at entry");

endmodule
